// File: hw/rtl/midi_running_status_parser_defines.svh
// Assertion macros used by the MIDI running status parser RTL.
`ifndef MIDI_RUNNING_STATUS_PARSER_DEFINES_SVH
`define MIDI_RUNNING_STATUS_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define MRSP_ASSERT_IMPL(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MRSP_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MRSP_ASSERT_IMPL(label, clock, reset, ante, cons, msg)
`define MRSP_ASSERT_NEXT(label, clock, reset, ante, cons, msg)

`endif

`endif

// File: hw/rtl/mrsp_pkg.sv
// Types and constants of the MIDI running status parser.
`default_nettype none

package mrsp_pkg;

  localparam logic [7:0] REALTIME_MIN = 8'hF8;
  localparam logic [7:0] SYSTEM_MIN   = 8'hF0;
  localparam logic [7:0] STATUS_MIN   = 8'h80;
  localparam logic [3:0] HI_PROG      = 4'hC;
  localparam logic [3:0] HI_PRESSURE  = 4'hD;

  localparam logic [1:0] HELD_NONE   = 2'd0;
  localparam logic [1:0] HELD_STATUS = 2'd1;
  localparam logic [1:0] HELD_FIRST  = 2'd2;

  localparam logic KIND_CHANNEL  = 1'b0;
  localparam logic KIND_REALTIME = 1'b1;

  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  typedef struct packed {
    logic [7:0] running_status;
    logic [1:0] bytes_held;
    logic [6:0] held_data;
  } mrsp_state_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] status_byte;
    logic [6:0] data_first;
    logic [6:0] data_second;
    logic [1:0] message_length;
  } mrsp_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/mrsp_decode.sv
// Byte classifier and message assembler: next parser state and result for one byte.
`default_nettype none

module mrsp_decode
  import mrsp_pkg::*;
(
  input  logic [7:0]   rx_byte,
  input  mrsp_state_t  state,
  output mrsp_state_t  state_next,
  output mrsp_result_t result
);

  logic [1:0] held_eff;
  logic       one_data;

  always_comb begin
    state_next = state;
    result     = '0;

    // A data byte with no open message restarts one from the running status.
    if (state.bytes_held == HELD_STATUS || state.bytes_held == HELD_FIRST) begin
      held_eff = state.bytes_held;
    end else if (state.running_status == 8'h00) begin
      held_eff = HELD_NONE;
    end else begin
      held_eff = HELD_STATUS;
    end

    one_data = (state.running_status[7:4] == HI_PROG) ||
               (state.running_status[7:4] == HI_PRESSURE);

    priority if (rx_byte >= REALTIME_MIN) begin
      result.valid          = 1'b1;
      result.kind           = KIND_REALTIME;
      result.status_byte    = rx_byte;
      result.message_length = LEN_ONE;
    end else if (rx_byte >= SYSTEM_MIN) begin
      state_next.running_status = 8'h00;
      state_next.bytes_held     = HELD_NONE;
    end else if (rx_byte >= STATUS_MIN) begin
      state_next.running_status = rx_byte;
      state_next.bytes_held     = HELD_STATUS;
    end else begin
      unique case (held_eff)
        HELD_STATUS: begin
          if (one_data) begin
            state_next.bytes_held = HELD_NONE;
            result.valid          = 1'b1;
            result.kind           = KIND_CHANNEL;
            result.status_byte    = state.running_status;
            result.data_first     = rx_byte[6:0];
            result.message_length = LEN_TWO;
          end else begin
            state_next.held_data  = rx_byte[6:0];
            state_next.bytes_held = HELD_FIRST;
          end
        end
        HELD_FIRST: begin
          state_next.bytes_held = HELD_NONE;
          result.valid          = 1'b1;
          result.kind           = KIND_CHANNEL;
          result.status_byte    = state.running_status;
          result.data_first     = state.held_data;
          result.data_second    = rx_byte[6:0];
          result.message_length = LEN_THREE;
        end
        default: begin
          state_next.bytes_held = HELD_NONE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/midi_running_status_parser.sv
// Top level of the MIDI running status parser.
//
//   Channel  Direction  tdata                                    tuser
//   s_axis   in         rx_byte[7:0]                             -
//   m_axis   out        status, data_first, data_second, length  kind
//
// One byte is taken per cycle when both sides keep up; a byte is first held in the input
// register and its result, if any, is then captured in the output register.
// Parser state is updated as a byte moves from the input register to the output stage.
// rst clears the running status, the open message and both valid flags.
// A stalled output holds its word; the input register then fills and s_axis_tready drops.
`default_nettype none

module midi_running_status_parser
  import mrsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] status_byte, [14:8] data_first,
                                      // [21:15] data_second, [23:22] message_length
  output logic        m_axis_tuser    // [0] kind
);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         out_free;
  logic         advance;

  mrsp_state_t  state;
  mrsp_state_t  state_next;
  mrsp_result_t result;

  logic         out_valid;
  logic         out_kind;
  logic [23:0]  out_data;

  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || advance;

  mrsp_decode u_decode (
    .rx_byte    (in_byte),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        state     <= state_next;
        out_valid <= result.valid;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset; each is loaded whenever its valid flag is set.
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
    if (advance && result.valid) begin
      out_kind <= result.kind;
      out_data <= {result.message_length, result.data_second,
                   result.data_first, result.status_byte};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_kind;

`include "midi_running_status_parser_defines.svh"

  `MRSP_ASSERT_IMPL(a_held_in_range, clk, rst, 1'b1, state.bytes_held != 2'd3,
                    "bytes held reached three")
  `MRSP_ASSERT_IMPL(a_open_needs_status, clk, rst, state.bytes_held != HELD_NONE,
                    state.running_status[7] && (state.running_status[7:4] != 4'hF),
                    "open message without running status")
  `MRSP_ASSERT_IMPL(a_realtime_shape, clk, rst, out_valid && (out_kind == KIND_REALTIME),
                    (out_data[23:22] == LEN_ONE) && (out_data[21:8] == 14'd0) &&
                    (out_data[7:3] == 5'h1F), "malformed realtime word")
  `MRSP_ASSERT_IMPL(a_channel_shape, clk, rst, out_valid && (out_kind == KIND_CHANNEL),
                    out_data[7] && (out_data[7:4] != 4'hF) && (out_data[23:22] != 2'd0) &&
                    (out_data[23:22] != LEN_ONE), "malformed channel word")
  `MRSP_ASSERT_NEXT(a_stall_holds_state, clk, rst, in_valid && !out_free,
                    $stable(state.bytes_held) && $stable(state.running_status),
                    "parser state moved during a stall")

endmodule

`default_nettype wire
